// ===== design/ffsa_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ffsa_pkg
// Shared constants, types and helpers of the first free slot allocator.
// ----------------------------------------------------------------------------
package ffsa_pkg;

   localparam int SLOTS      = 64;
   localparam int OWNER_BITS = 16;
   localparam int IDX_W      = $clog2(SLOTS);
   localparam int CNT_W      = $clog2(SLOTS + 1);

   typedef logic [IDX_W-1:0]      idx_type;
   typedef logic [CNT_W-1:0]      cnt_type;
   typedef logic [OWNER_BITS-1:0] owner_type;
   typedef logic [SLOTS-1:0]      slot_vec_type;

   typedef enum logic [1:0] {
      REQ_RESERVE = 2'd0,
      REQ_RELEASE = 2'd1,
      REQ_QUERY   = 2'd2
   } req_kind_type;

   typedef enum logic {
      ST_IDLE = 1'b0,
      ST_EXEC = 1'b1
   } state_type;

   typedef enum logic {
      STATUS_OK   = 1'b0,
      STATUS_FAIL = 1'b1
   } status_type;

   // command from the control logic to the owner memory
   typedef struct packed {
      logic      rd_en;
      idx_type   rd_addr;
      logic      wr_en;
      idx_type   wr_addr;
      owner_type wr_data;
   } mem_cmd_type;

   typedef struct packed {
      logic    found;
      idx_type index;
   } first_free_type;

   // lowest set bit of the vector
   function automatic first_free_type find_first(input slot_vec_type vec);
      first_free_type res;
      res.found = 1'b0;
      res.index = '0;
      for (int i = SLOTS - 1; i >= 0; i--) begin
         if (vec[i]) begin
            res.found = 1'b1;
            res.index = IDX_W'(i);
         end
      end
      return res;
   endfunction

endpackage
`default_nettype wire

// ===== design/ffsa_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ffsa_if
// Valid/ready channels for allocator requests and responses.
// ----------------------------------------------------------------------------
interface ffsa_req_if;
   logic                           valid;
   logic                           ready;
   logic [1:0]                     req_type;
   logic [ffsa_pkg::OWNER_BITS-1:0] owner_id;
   logic [ffsa_pkg::IDX_W-1:0]      slot_index;

   modport source (output valid, output req_type, output owner_id, output slot_index,
                   input ready);
   modport sink   (input valid, input req_type, input owner_id, input slot_index,
                   output ready);
endinterface

interface ffsa_rsp_if;
   logic                           valid;
   logic                           ready;
   logic                           status;
   logic [ffsa_pkg::IDX_W-1:0]      slot_index_res;
   logic [ffsa_pkg::OWNER_BITS-1:0] owner_id_res;
   logic [ffsa_pkg::CNT_W-1:0]      occupied_count;
   logic [ffsa_pkg::CNT_W-1:0]      free_count;

   modport source (output valid, output status, output slot_index_res,
                   output owner_id_res, output occupied_count, output free_count,
                   input ready);
   modport sink   (input valid, input status, input slot_index_res,
                   input owner_id_res, input occupied_count, input free_count,
                   output ready);
endinterface
`default_nettype wire

// ===== design/first_free_slot_allocator_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// first_free_slot_allocator_core
// First-fit slot allocator with an owner memory and an occupancy bitmap.
// ----------------------------------------------------------------------------
// In the accept cycle (state IDLE) the owner memory is read at the
// requested slot, and in state EXEC the registered read data,
// the occupancy bitmap and its first-free encoder decide the result, the
// memory and bitmap are updated and the response register is loaded. The
// next item is taken while a response still waits; if the response register
// is still full at the end of an item, that item holds until it drains.
// Writing capacity clears the bitmap and occupied count directly; there
// is no clearing pass. Capacities above 64 act as 64.
module first_free_slot_allocator_core (
   input  wire                            clock,
   input  wire                            reset,
   input  wire                            csr_we,
   input  wire [ffsa_pkg::CNT_W-1:0]      csr_wdata,
   ffsa_req_if.sink                       req_ch,
   ffsa_rsp_if.source                     rsp_ch
);
   import ffsa_pkg::*;

   state_type    state_ff, state_in;
   cnt_type      capacity_ff;
   slot_vec_type occ_ff, occ_in;
   cnt_type      count_ff, count_in;

   logic [1:0]   kind_ff;
   owner_type    owner_ff;
   idx_type      index_ff;

   logic         rsp_valid_ff, rsp_valid_in;
   logic         status_ff, status_in;
   idx_type      idx_res_ff, idx_res_in;
   owner_type    owner_res_ff, owner_res_in;
   cnt_type      occ_cnt_ff, occ_cnt_in;
   cnt_type      free_cnt_ff, free_cnt_in;

   mem_cmd_type    mem_cmd;
   owner_type      rd_data;
   cnt_type        cap_eff;
   slot_vec_type   enable_mask;
   first_free_type first_free;
   logic           req_fire;
   logic           exec_go;
   logic           has_table;
   logic           idx_ok;

   ffsa_owner_mem u_owner_mem (
      .clock   (clock),
      .cmd     (mem_cmd),
      .rd_data (rd_data)
   );

   assign cap_eff = (capacity_ff > CNT_W'(SLOTS)) ? CNT_W'(SLOTS) : capacity_ff;

   for (genvar i = 0; i < SLOTS; i++) begin : g_mask
      assign enable_mask[i] = (CNT_W'(i) < cap_eff);
   end

   assign first_free = find_first(~occ_ff & enable_mask);
   assign has_table  = (cap_eff != '0);
   assign idx_ok     = ({1'b0, index_ff} < cap_eff);

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign req_fire     = req_ch.valid && req_ch.ready;
   assign exec_go      = (state_ff == ST_EXEC) && (!rsp_valid_ff || rsp_ch.ready);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (exec_go) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // item evaluation and updates
   always_comb begin
      occ_in       = occ_ff;
      count_in     = count_ff;
      status_in    = STATUS_FAIL;
      idx_res_in   = index_ff;
      owner_res_in = '0;

      mem_cmd.rd_en   = req_fire;
      mem_cmd.rd_addr = req_ch.slot_index;
      mem_cmd.wr_en   = 1'b0;
      mem_cmd.wr_addr = first_free.index;
      mem_cmd.wr_data = owner_ff;

      if (has_table) begin
         case (kind_ff)
            REQ_RESERVE: begin
               if (owner_ff != '0 && first_free.found) begin
                  occ_in[first_free.index] = 1'b1;
                  count_in      = count_ff + cnt_type'(1);
                  idx_res_in    = first_free.index;
                  status_in     = STATUS_OK;
                  mem_cmd.wr_en = exec_go;
               end
            end
            REQ_RELEASE: begin
               if (idx_ok) begin
                  status_in = STATUS_OK;
                  if (occ_ff[index_ff]) begin
                     owner_res_in     = rd_data;
                     occ_in[index_ff] = 1'b0;
                     if (count_ff != '0) begin
                        count_in = count_ff - cnt_type'(1);
                     end
                  end
               end
            end
            REQ_QUERY: begin
               if (idx_ok) begin
                  status_in = STATUS_OK;
                  if (occ_ff[index_ff]) begin
                     owner_res_in = rd_data;
                  end
               end
            end
            default: status_in = STATUS_FAIL;
         endcase
      end

      occ_cnt_in  = has_table ? count_in : '0;
      free_cnt_in = (has_table && cap_eff >= count_in) ? cap_eff - count_in : '0;

      rsp_valid_in = rsp_valid_ff;
      if (exec_go) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         capacity_ff  <= '0;
         occ_ff       <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            capacity_ff <= csr_wdata;
            occ_ff      <= '0;
            count_ff    <= '0;
         end else if (exec_go) begin
            occ_ff   <= occ_in;
            count_ff <= count_in;
         end
      end
   end

   // request and response payload
   always_ff @(posedge clock) begin
      if (req_fire) begin
         kind_ff  <= req_ch.req_type;
         owner_ff <= req_ch.owner_id;
         index_ff <= req_ch.slot_index;
      end
      if (exec_go) begin
         status_ff    <= status_in;
         idx_res_ff   <= idx_res_in;
         owner_res_ff <= owner_res_in;
         occ_cnt_ff   <= occ_cnt_in;
         free_cnt_ff  <= free_cnt_in;
      end
   end

   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.status         = status_ff;
   assign rsp_ch.slot_index_res = idx_res_ff;
   assign rsp_ch.owner_id_res   = owner_res_ff;
   assign rsp_ch.occupied_count = occ_cnt_ff;
   assign rsp_ch.free_count     = free_cnt_ff;

endmodule
`default_nettype wire

// ===== design/ffsa_owner_mem.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ffsa_owner_mem
// Owner id storage: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module ffsa_owner_mem (
   input  wire                        clock,
   input  wire ffsa_pkg::mem_cmd_type cmd,
   output ffsa_pkg::owner_type        rd_data
);
   import ffsa_pkg::*;

   owner_type mem_array [SLOTS];
   owner_type rd_data_ff;

   // entries are only trusted where the occupancy bit is set
   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem_array[cmd.wr_addr] <= cmd.wr_data;
      end
      if (cmd.rd_en) begin
         rd_data_ff <= mem_array[cmd.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// ===== tb/sv/tb_first_free_slot_allocator_core.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_first_free_slot_allocator_core
// Drives reserve, release, query and unknown requests into the allocator under
// several capacities and handshake idling patterns. A shadow copy of the slot
// table predicts every response, and each response is checked field by field.
// ----------------------------------------------------------------------------
module tb_first_free_slot_allocator_core;
   import ffsa_pkg::*;

   localparam logic [1:0] REQ_UNKNOWN = 2'd3;
   localparam int PHASE_ITEMS = 160;

   typedef struct packed {
      status_type status;
      idx_type    slot;
      owner_type  owner;
      cnt_type    occupied;
      cnt_type    free_cnt;
   } alloc_result_type;

   logic    clock = 1'b0;
   logic    reset;
   logic    csr_we;
   cnt_type csr_wdata;

   ffsa_req_if req_bus();
   ffsa_rsp_if rsp_bus();

   first_free_slot_allocator_core dut (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .req_ch    (req_bus),
      .rsp_ch    (rsp_bus)
   );

   // shadow of the slot table
   owner_type owner_shadow [SLOTS];
   int        used_shadow;
   int        capacity_shadow;

   alloc_result_type alloc_results_due [$];
   int               error_count = 0;
   int               tx_idle_pct = 0;
   int               rx_idle_pct = 0;
   int               hold_left   = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #10_000_000;
      $display("Verification failed");
      $finish;
   end

   function automatic int effective_capacity();
      return (capacity_shadow > SLOTS) ? SLOTS : capacity_shadow;
   endfunction

   function automatic alloc_result_type predict_allocation(logic [1:0] kind, owner_type owner,
                                                           idx_type idx);
      alloc_result_type r;
      int               cap;
      bit               granted;
      cap      = effective_capacity();
      granted  = 1'b0;
      r.status = STATUS_FAIL;
      r.slot   = idx;
      r.owner  = '0;
      if (cap != 0) begin
         case (kind)
            REQ_RESERVE: begin
               if (owner != '0) begin
                  for (int i = 0; i < cap && !granted; i++) begin
                     if (owner_shadow[i] == '0) begin
                        owner_shadow[i] = owner;
                        used_shadow++;
                        r.slot   = idx_type'(i);
                        r.status = STATUS_OK;
                        granted  = 1'b1;
                     end
                  end
               end
            end
            REQ_RELEASE: begin
               if (idx < cap) begin
                  r.owner = owner_shadow[idx];
                  if (r.owner != '0) begin
                     owner_shadow[idx] = '0;
                     if (used_shadow != 0) used_shadow--;
                  end
                  r.status = STATUS_OK;
               end
            end
            REQ_QUERY: begin
               if (idx < cap) begin
                  r.owner  = owner_shadow[idx];
                  r.status = STATUS_OK;
               end
            end
            default: ;
         endcase
      end
      r.occupied = (cap != 0) ? cnt_type'(used_shadow) : '0;
      r.free_cnt = (cap != 0 && cap >= used_shadow) ? cnt_type'(cap - used_shadow) : '0;
      return r;
   endfunction

   task automatic wait_drain();
      while (alloc_results_due.size() != 0) @(posedge clock);
   endtask

   task automatic send_item(logic [1:0] kind, owner_type owner, idx_type idx);
      int gap;
      gap = 0;
      while ($urandom_range(99) < tx_idle_pct) gap++;
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.req_type   <= kind;
      req_bus.owner_id   <= owner;
      req_bus.slot_index <= idx;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      alloc_results_due.push_back(predict_allocation(kind, owner, idx));
   endtask

   // only while idle: drop valid, drain, then write the register
   task automatic write_capacity(cnt_type value);
      req_bus.valid <= 1'b0;
      wait_drain();
      repeat (2) @(posedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= value;
      capacity_shadow = value;
      used_shadow     = 0;
      foreach (owner_shadow[i]) owner_shadow[i] = '0;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic check_field(string name, int unsigned want, int unsigned got);
      if (want !== got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         error_count++;
      end
   endtask

   // response side: random stalls, or a long hold-off when requested
   initial begin
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_left > 0) begin
            rsp_bus.ready <= 1'b0;
            hold_left--;
         end else begin
            rsp_bus.ready <= ($urandom_range(99) >= rx_idle_pct);
         end
      end
   end

   always @(posedge clock) begin
      alloc_result_type want;
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         if (alloc_results_due.size() == 0) begin
            $error("response item with no request outstanding");
            error_count++;
         end else begin
            want = alloc_results_due.pop_front();
            check_field("status", want.status, rsp_bus.status);
            check_field("slot_index_res", want.slot, rsp_bus.slot_index_res);
            check_field("owner_id_res", want.owner, rsp_bus.owner_id_res);
            check_field("occupied_count", want.occupied, rsp_bus.occupied_count);
            check_field("free_count", want.free_cnt, rsp_bus.free_count);
         end
      end
   end

   // capacity is zero out of reset, so everything fails
   task automatic test_no_table();
      send_item(REQ_RESERVE, 16'hFFFF, 6'd0);
      send_item(REQ_RELEASE, 16'h0001, 6'd0);
      send_item(REQ_QUERY, 16'h0000, 6'd63);
      send_item(REQ_UNKNOWN, 16'hFFFF, 6'd63);
   endtask

   task automatic test_reserve_release_query();
      write_capacity(cnt_type'(3));
      send_item(REQ_RESERVE, 16'h0000, 6'd5);
      send_item(REQ_RESERVE, 16'hFFFF, 6'd0);
      send_item(REQ_RESERVE, 16'h0001, 6'd63);
      send_item(REQ_RESERVE, 16'h8000, 6'd0);
      send_item(REQ_RESERVE, 16'h1234, 6'd0);
      send_item(REQ_QUERY, 16'h0000, 6'd0);
      send_item(REQ_QUERY, 16'h0000, 6'd2);
      send_item(REQ_QUERY, 16'h0000, 6'd3);
      send_item(REQ_RELEASE, 16'h0000, 6'd1);
      send_item(REQ_RELEASE, 16'h0000, 6'd1);
      send_item(REQ_RESERVE, 16'h5A5A, 6'd0);
      send_item(REQ_RELEASE, 16'h0000, 6'd63);
      send_item(REQ_UNKNOWN, 16'h0001, 6'd0);
   endtask

   // above the table size the capacity saturates; also the smallest table
   task automatic test_capacity_extremes();
      write_capacity(cnt_type'(127));
      send_item(REQ_RESERVE, 16'hFFFF, 6'd0);
      send_item(REQ_RELEASE, 16'h0000, 6'd63);
      send_item(REQ_QUERY, 16'h0000, 6'd63);
      write_capacity(cnt_type'(SLOTS));
      send_item(REQ_QUERY, 16'h0000, 6'd0);
      write_capacity(cnt_type'(1));
      send_item(REQ_RESERVE, 16'h00FF, 6'd0);
      send_item(REQ_RESERVE, 16'hFF00, 6'd0);
      send_item(REQ_QUERY, 16'h0000, 6'd1);
      send_item(REQ_RELEASE, 16'h0000, 6'd0);
   endtask

   task automatic test_random_traffic(int tx_pct, int rx_pct);
      int         pick;
      int         cap;
      logic [1:0] kind;
      owner_type  owner;
      idx_type    idx;
      tx_idle_pct = tx_pct;
      rx_idle_pct = rx_pct;
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0:       write_capacity(cnt_type'($urandom_range(8, 1)));
            1:       write_capacity(cnt_type'($urandom_range(127, SLOTS)));
            2:       write_capacity(cnt_type'($urandom_range(SLOTS - 1, 9)));
            default: write_capacity(cnt_type'($urandom_range(127, 0)));
         endcase
         cap = effective_capacity();
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            pick = $urandom_range(99);
            if (pick < 45)      kind = REQ_RESERVE;
            else if (pick < 75) kind = REQ_RELEASE;
            else if (pick < 95) kind = REQ_QUERY;
            else                kind = REQ_UNKNOWN;
            owner = ($urandom_range(19) == 0) ? '0 : owner_type'($urandom);
            // mostly in range so the table fills and drains
            if (cap != 0 && $urandom_range(9) != 0)
               idx = idx_type'($urandom_range(cap - 1));
            else
               idx = idx_type'($urandom_range(SLOTS - 1));
            send_item(kind, owner, idx);
         end
      end
   endtask

   // long response hold-off while requests keep coming, then a full drain
   task automatic test_backpressure();
      tx_idle_pct = 0;
      rx_idle_pct = 0;
      write_capacity(cnt_type'(SLOTS));
      hold_left = 300;
      for (int n = 0; n < 60; n++)
         send_item((n % 4 == 3) ? REQ_QUERY : REQ_RESERVE, owner_type'(n + 1),
                   idx_type'(n % SLOTS));
      req_bus.valid <= 1'b0;
      wait_drain();
   endtask

   initial begin
      reset              <= 1'b1;
      csr_we             <= 1'b0;
      csr_wdata          <= '0;
      req_bus.valid      <= 1'b0;
      req_bus.req_type   <= REQ_RESERVE;
      req_bus.owner_id   <= '0;
      req_bus.slot_index <= '0;
      capacity_shadow = 0;
      used_shadow     = 0;
      foreach (owner_shadow[i]) owner_shadow[i] = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_no_table();
      test_reserve_release_query();
      test_capacity_extremes();
      test_random_traffic(14, 50);
      test_random_traffic(50, 14);
      test_random_traffic(0, 0);
      test_backpressure();

      req_bus.valid <= 1'b0;
      wait_drain();
      repeat (20) @(posedge clock);
      if (error_count == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
